// File: rtl/core/nidchk_pkg.sv
package nidchk_pkg;

  // one character of the identity number
  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } nidchk_in_t;

  // decoded number, one per identity number
  typedef struct packed {
    logic        valid_res;
    logic [3:0]  expected_check;
    logic [11:0] birth_year;
    logic [3:0]  birth_month;
    logic [6:0]  birth_day;
  } nidchk_out_t;

  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_YEAR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_YEAR = 1'd1;

  localparam logic [11:0] MIN_YEAR_RST = 12'd1900;
  localparam logic [11:0] MAX_YEAR_RST = 12'd2299;

  localparam logic [3:0] NUM_LEN = 4'd11;
  localparam logic [3:0] SUM_LEN = 4'd10;
  localparam logic [3:0] POS_MAX = 4'd15;

  // digit weights repeat every four positions
  localparam logic [3:0] WEIGHT_TAB [4] = '{4'd1, 4'd3, 4'd7, 4'd9};

  localparam logic [11:0] BASE_1900 = 12'd1900;
  localparam logic [11:0] BASE_2000 = 12'd2000;
  localparam logic [11:0] BASE_2100 = 12'd2100;
  localparam logic [11:0] BASE_2200 = 12'd2200;

  // remainder by ten for values below 128, reciprocal multiply
  function automatic logic [3:0] mod10(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  q;
    logic [6:0]  r;
    prod = 15'(v) * 15'd205;
    q    = prod[14:11];
    r    = v - 7'(q) * 7'd10;
    return r[3:0];
  endfunction

endpackage

// File: rtl/core/national_id_check_and_date_validator.sv
// channel  | direction | handshake          | payload
// ---------+-----------+--------------------+-------------------------------------
// in_      | input     | in_valid/in_stall  | in_data: char_code, last
// out_     | output    | out_valid/out_stall| out_data: valid_res, check, birth date
// cfg_     | input     | cfg_we             | cfg_index, cfg_wdata (min/max year)
//
// one character is taken per cycle while in_stall is low; the per-number digit state updates in
// the cycle of the transfer, so characters stream back to back
// the character marked last hands a snapshot to a decode register; out_valid
// rises when that snapshot moves on to the result register (snapshot reg,
// then result reg), which waits while a held result is stalled
// rst_n is synchronous; it clears the digit state, both stages and restores
// the year bounds to 1900 and 2299
// a stalled result holds; in_stall rises only when snapshot and result
// registers are both full and the output is stalled
module national_id_check_and_date_validator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  nidchk_pkg::nidchk_in_t            in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output nidchk_pkg::nidchk_out_t           out_data,
  input  logic                              cfg_we,
  input  logic [nidchk_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nidchk_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import nidchk_pkg::*;

  // digit state handed from the character stage to the decode stage
  typedef struct packed {
    logic [3:0] count;
    logic [3:0] sum;
    logic [6:0] year_digits;
    logic [6:0] month_code;
    logic [6:0] day_digits;
    logic [3:0] final_digit;
    logic       bad_char;
  } nidchk_snap_t;

  // configuration
  logic [11:0] min_year_r;
  logic [11:0] max_year_r;

  // per-number running state
  nidchk_snap_t st_r;
  nidchk_snap_t st_nxt;

  // snapshot of a finished number
  logic         snap_vld_r;
  nidchk_snap_t snap_r;

  // result register
  logic         out_vld_r;
  nidchk_out_t  out_r;
  nidchk_out_t  res_nxt;

  logic in_xfer;
  logic adv_out;

  assign adv_out  = !out_vld_r || !out_stall;
  assign in_stall = snap_vld_r && !adv_out;
  assign in_xfer  = in_valid && !in_stall;

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // ---------------------------------------------------------------------
  // character stage: digit decode and running weighted sum
  // ---------------------------------------------------------------------
  logic       is_digit;
  logic [3:0] dig;
  logic [6:0] dig_x10;
  logic [3:0] pos;
  logic [6:0] term;

  always_comb begin
    is_digit = (in_data.char_code >= 8'h30) && (in_data.char_code <= 8'h39);
    // a non-digit counts as zero in the sum and the date fields
    dig      = is_digit ? in_data.char_code[3:0] : 4'd0;
    dig_x10  = 7'(dig) * 7'd10;
    pos      = st_r.count;
    term     = 7'(WEIGHT_TAB[pos[1:0]]) * 7'(dig);

    st_nxt          = st_r;
    st_nxt.bad_char = st_r.bad_char | !is_digit;
    if (pos < SUM_LEN) begin
      st_nxt.sum = mod10(7'(st_r.sum) + term);
    end
    unique case (pos)
      4'd0:    st_nxt.year_digits = dig_x10;
      4'd1:    st_nxt.year_digits = st_r.year_digits + 7'(dig);
      4'd2:    st_nxt.month_code  = dig_x10;
      4'd3:    st_nxt.month_code  = st_r.month_code + 7'(dig);
      4'd4:    st_nxt.day_digits  = dig_x10;
      4'd5:    st_nxt.day_digits  = st_r.day_digits + 7'(dig);
      4'd10:   st_nxt.final_digit = dig;
      default: ;
    endcase
    // count saturates so long numbers stay invalid
    st_nxt.count = (pos < POS_MAX) ? pos + 4'd1 : POS_MAX;
  end

  // ---------------------------------------------------------------------
  // decode stage: check digit, century, calendar, year bounds
  // ---------------------------------------------------------------------
  logic        month_ok;
  logic [11:0] base;
  logic [6:0]  off;
  logic [11:0] year;
  logic [3:0]  month;
  logic        leap;
  logic [4:0]  mdays;
  logic [3:0]  chk;
  logic        ok;

  always_comb begin
    chk = (snap_r.sum == 4'd0) ? 4'd0 : 4'd10 - snap_r.sum;

    month_ok = 1'b1;
    base     = BASE_1900;
    off      = 7'd0;
    priority if (snap_r.month_code >= 7'd1 && snap_r.month_code <= 7'd12) begin
      base = BASE_1900;
      off  = 7'd0;
    end else if (snap_r.month_code >= 7'd21 && snap_r.month_code <= 7'd32) begin
      base = BASE_2000;
      off  = 7'd20;
    end else if (snap_r.month_code >= 7'd41 && snap_r.month_code <= 7'd52) begin
      base = BASE_2100;
      off  = 7'd40;
    end else if (snap_r.month_code >= 7'd61 && snap_r.month_code <= 7'd72) begin
      base = BASE_2200;
      off  = 7'd60;
    end else begin
      // 1800s codes and anything else
      month_ok = 1'b0;
    end

    year  = month_ok ? base + 12'(snap_r.year_digits) : 12'd0;
    month = month_ok ? 4'(snap_r.month_code - off) : 4'd0;

    // every century base is a multiple of four, so the year digits decide
    // divisibility by four; a century year is leap only for 2000
    leap = (snap_r.year_digits[1:0] == 2'd0) &&
           ((snap_r.year_digits != 7'd0) || (base == BASE_2000));

    unique case (month)
      4'd2:                       mdays = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:    mdays = 5'd30;
      default:                    mdays = 5'd31;
    endcase

    ok = (snap_r.count == NUM_LEN) && !snap_r.bad_char && month_ok &&
         (year >= min_year_r) && (year <= max_year_r) &&
         (snap_r.day_digits >= 7'd1) && (snap_r.day_digits <= 7'(mdays)) &&
         (chk == snap_r.final_digit);

    res_nxt.valid_res      = ok;
    res_nxt.expected_check = chk;
    res_nxt.birth_year     = year;
    res_nxt.birth_month    = month;
    res_nxt.birth_day      = snap_r.day_digits;
  end

  // ---------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_year_r <= MIN_YEAR_RST;
      max_year_r <= MAX_YEAR_RST;
      st_r       <= '0;
      snap_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MIN_YEAR: min_year_r <= cfg_wdata;
          CFG_MAX_YEAR: max_year_r <= cfg_wdata;
          default:      ;
        endcase
      end

      // decode stage drains into the result register
      if (adv_out) begin
        out_vld_r <= snap_vld_r;
        if (snap_vld_r) begin
          out_r <= res_nxt;
        end
      end

      // a new snapshot refills the stage in the cycle it drains
      if (in_xfer && in_data.last) begin
        snap_vld_r <= 1'b1;
      end else if (adv_out) begin
        snap_vld_r <= 1'b0;
      end

      if (in_xfer) begin
        if (in_data.last) begin
          // finished number moves on, state clears for the next one
          snap_r <= st_nxt;
          st_r   <= '0;
        end else begin
          st_r <= st_nxt;
        end
      end
    end
  end

endmodule

// File: rtl/core/nidchk_checker.sv
module nidchk_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input nidchk_pkg::nidchk_in_t            in_data,
  input logic                              out_valid,
  input logic                              out_stall,
  input nidchk_pkg::nidchk_out_t           out_data
);
  import nidchk_pkg::*;

  // stalled character holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled character changed");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // reset empties the result register
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // an accepted number carries an in-range month, day and year
  a_valid_date: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.valid_res |->
      out_data.birth_month >= 4'd1 && out_data.birth_month <= 4'd12 &&
      out_data.birth_day >= 7'd1 && out_data.birth_day <= 7'd31 &&
      out_data.birth_year >= 12'd1900 && out_data.birth_year <= 12'd2299)
    else $error("valid result with impossible date");

  // bad month code zeroes year and month and fails the number; check digit is decimal
  a_bad_month: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.birth_month == 4'd0 |->
      out_data.birth_year == 12'd0 && !out_data.valid_res &&
      out_data.expected_check <= 4'd9)
    else $error("invalid month code not reflected in result");

endmodule

bind national_id_check_and_date_validator nidchk_checker u_nidchk_checker (.*);

// File: test/tb_national_id_check_and_date_validator.sv
module tb_national_id_check_and_date_validator;
  timeunit 1ns;
  timeprecision 1ps;

  import nidchk_pkg::*;

  // generous cap: ~1350 characters, each with a random gap in front plus stalls
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_CHARS = 1100;
  localparam int unsigned NUM_PHASES = 7;
  // weights on characters one to ten of the number
  localparam int DIGIT_WEIGHTS [10] = '{1, 3, 7, 9, 1, 3, 7, 9, 1, 3};

  // one directed row: characters right-justified in text, first in the highest used byte
  typedef struct packed {
    logic [4:0]   len;
    logic [127:0] text;
    logic         close;   // set last on the final character
    logic         pinned;  // result typed in below instead of predicted
    nidchk_out_t  want;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  nidchk_in_t            in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  nidchk_out_t           out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_MIN_YEAR;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // shadow of the per-number digit state and the year bounds
  logic [3:0]  id_pos = '0;
  logic [3:0]  id_sum = '0;
  logic [6:0]  id_year = '0;
  logic [6:0]  id_month = '0;
  logic [6:0]  id_day = '0;
  logic [3:0]  id_final = '0;
  logic        id_bad = 1'b0;
  logic [11:0] year_lo = MIN_YEAR_RST;
  logic [11:0] year_hi = MAX_YEAR_RST;

  nidchk_out_t decoded_q [$];
  dir_row_t    dir_tab [$];
  logic        pin_next = 1'b0;
  nidchk_out_t pinned_res = '0;

  // when set, neither side inserts gaps or stalls
  logic        calm = 1'b0;
  int unsigned chars_sent = 0;
  int unsigned results_seen = 0;
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;

  national_id_check_and_date_validator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int days_of(int m, int y);
    logic leap;
    leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    case (m)
      2: return leap ? 29 : 28;
      4, 6, 9, 11: return 30;
      default: return 31;
    endcase
  endfunction

  // fold one accepted character into the shadow state; on last, queue the decode
  task automatic absorb_char(logic [7:0] c, logic l);
    logic [3:0]  d;
    int          chk;
    int          base;
    int          off;
    int          yr;
    int          mo;
    logic        ok;
    nidchk_out_t r;
    d = '0;
    if (c >= 8'h30 && c <= 8'h39) d = 4'(c - 8'h30);
    else id_bad = 1'b1;  // non-digit counts as zero but spoils the number
    if (id_pos < 10) id_sum = 4'((id_sum + DIGIT_WEIGHTS[id_pos] * d) % 10);
    case (id_pos)
      4'd0: id_year = 7'(d * 10);
      4'd1: id_year = id_year + 7'(d);
      4'd2: id_month = 7'(d * 10);
      4'd3: id_month = id_month + 7'(d);
      4'd4: id_day = 7'(d * 10);
      4'd5: id_day = id_day + 7'(d);
      4'd10: id_final = d;
      default: ;
    endcase
    // count saturates on overlong numbers
    if (id_pos != 4'd15) id_pos = id_pos + 4'd1;
    if (!l) return;

    chk = (10 - id_sum) % 10;
    off = -1;
    base = 0;
    if (id_month >= 1 && id_month <= 12) begin
      base = 1900;
      off = 0;
    end else if (id_month >= 21 && id_month <= 32) begin
      base = 2000;
      off = 20;
    end else if (id_month >= 41 && id_month <= 52) begin
      base = 2100;
      off = 40;
    end else if (id_month >= 61 && id_month <= 72) begin
      base = 2200;
      off = 60;
    end
    // 1800s codes fall through as bad month codes
    yr = (off >= 0) ? base + id_year : 0;
    mo = (off >= 0) ? id_month - off : 0;
    ok = (id_pos == 11) && !id_bad && (off >= 0);
    ok = ok && (yr >= year_lo) && (yr <= year_hi);
    ok = ok && (id_day >= 1) && (id_day <= days_of(mo, yr));
    ok = ok && (chk == id_final);

    r.valid_res      = ok;
    r.expected_check = 4'(chk);
    r.birth_year     = 12'(yr);
    r.birth_month    = 4'(mo);
    r.birth_day      = id_day;
    if (pin_next) begin
      decoded_q.push_back(pinned_res);
      pin_next = 1'b0;
    end else begin
      decoded_q.push_back(r);
    end

    id_pos = '0;
    id_sum = '0;
    id_year = '0;
    id_month = '0;
    id_day = '0;
    id_final = '0;
    id_bad = 1'b0;
  endtask

  // one character transfer, with a random gap in front
  task automatic send_char(logic [7:0] c, logic l);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{char_code: c, last: l};
    do @(posedge clk); while (in_stall);
    absorb_char(c, l);
    chars_sent++;
  endtask

  // drop valid and let every pending decode come out
  task automatic settle();
    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    // snapshot and result stages are two deep
    repeat (4) @(posedge clk);
  endtask

  // both bound registers in back-to-back writes
  task automatic set_bounds(logic [11:0] lo, logic [11:0] hi);
    cfg_we <= 1'b1;
    cfg_index <= CFG_MIN_YEAR;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_index <= CFG_MAX_YEAR;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_we <= 1'b0;
    year_lo = lo;
    year_hi = hi;
    @(posedge clk);
  endtask

  function automatic dir_row_t mk_row(int n, logic [127:0] s, logic cl, logic pin,
                                      nidchk_out_t w);
    dir_row_t r;
    r.len = 5'(n);
    r.text = s;
    r.close = cl;
    r.pinned = pin;
    r.want = w;
    return r;
  endfunction

  // mostly well-formed numbers with random content, some noise and damage
  task automatic make_number();
    logic [7:0] ch [16];
    int         dv [10];
    int         n;
    int         cc;
    int         mc;
    int         m;
    int         yy;
    int         y;
    int         dd;
    int         s;
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 15);
      for (int i = 0; i < n; i++) ch[i] = 8'($urandom_range(0, 255));
    end else begin
      yy = $urandom_range(0, 99);
      case ($urandom_range(0, 9))
        0, 1: cc = 0;
        2, 3, 4: cc = 20;
        5, 6: cc = 40;
        7: cc = 60;
        8: cc = 80;
        default: cc = -1;
      endcase
      m = $urandom_range(1, 12);
      y = (cc == 80) ? 1800 + yy : 1900 + cc * 5 + yy;
      mc = (cc < 0) ? $urandom_range(0, 99) : cc + m;
      // mostly real calendar days, sometimes anything two digits allow
      dd = ($urandom_range(0, 4) != 0) ? $urandom_range(1, days_of(m, y))
                                       : $urandom_range(0, 99);
      dv[0] = yy / 10;
      dv[1] = yy % 10;
      dv[2] = mc / 10;
      dv[3] = mc % 10;
      dv[4] = dd / 10;
      dv[5] = dd % 10;
      for (int i = 6; i < 10; i++) dv[i] = $urandom_range(0, 9);
      s = 0;
      for (int i = 0; i < 10; i++) begin
        s = s + DIGIT_WEIGHTS[i] * dv[i];
        ch[i] = 8'(8'h30 + dv[i]);
      end
      ch[10] = ($urandom_range(0, 3) != 0) ? 8'(8'h30 + (10 - s % 10) % 10)
                                           : 8'(8'h30 + $urandom_range(0, 9));
      for (int i = 11; i < 16; i++) ch[i] = 8'(8'h30 + $urandom_range(0, 9));
      n = ($urandom_range(0, 7) != 0) ? 11 : $urandom_range(1, 15);
      // occasional corrupted character anywhere in the number
      if ($urandom_range(0, 9) == 0) ch[$urandom_range(0, n - 1)] = 8'($urandom_range(0, 255));
    end
    for (int i = 0; i < n; i++) send_char(ch[i], i == n - 1);
  endtask

  // result side: random stall before each transfer
  initial begin
    int n;
    forever begin
      n = calm ? 0 : $urandom_range(0, 6);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(rst_n && out_valid));
    end
  end

  // compare each result transfer with the oldest pending decode
  always @(posedge clk) begin
    nidchk_out_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (decoded_q.size() == 0) begin
        $error("result with nothing pending: %p", out_data);
        err_cnt++;
      end else begin
        exp_r = decoded_q.pop_front();
        if (out_data.valid_res !== exp_r.valid_res) begin
          $error("valid_res exp %0d got %0d", exp_r.valid_res, out_data.valid_res);
          err_cnt++;
        end
        if (out_data.expected_check !== exp_r.expected_check) begin
          $error("expected_check exp %0d got %0d", exp_r.expected_check,
                 out_data.expected_check);
          err_cnt++;
        end
        if (out_data.birth_year !== exp_r.birth_year) begin
          $error("birth_year exp %0d got %0d", exp_r.birth_year, out_data.birth_year);
          err_cnt++;
        end
        if (out_data.birth_month !== exp_r.birth_month) begin
          $error("birth_month exp %0d got %0d", exp_r.birth_month, out_data.birth_month);
          err_cnt++;
        end
        if (out_data.birth_day !== exp_r.birth_day) begin
          $error("birth_day exp %0d got %0d", exp_r.birth_day, out_data.birth_day);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    dir_row_t    r;
    logic [11:0] lo_tab [NUM_PHASES];
    logic [11:0] hi_tab [NUM_PHASES];
    int unsigned quota;

    // a known good number, typed in
    dir_tab.push_back(mk_row(11, "44051401458", 1'b1, 1'b1,
                             nidchk_out_t'{1'b1, 4'd8, 12'd1944, 4'd5, 7'd14}));
    // same number split over two rows, no last in between
    dir_tab.push_back(mk_row(6, "440514", 1'b0, 1'b0, '0));
    dir_tab.push_back(mk_row(5, "01458", 1'b1, 1'b0, '0));
    // leap days: 2000 yes, 2100 no, 1904 yes, 1901 no
    dir_tab.push_back(mk_row(11, "00222912345", 1'b1, 1'b0, '0));
    dir_tab.push_back(mk_row(11, "00422912345", 1'b1, 1'b0, '0));
    dir_tab.push_back(mk_row(11, "04022912345", 1'b1, 1'b0, '0));
    dir_tab.push_back(mk_row(11, "01022912345", 1'b1, 1'b0, '0));
    // earliest and latest dates the month codes reach
    dir_tab.push_back(mk_row(11, "00010100000", 1'b1, 1'b0, '0));
    dir_tab.push_back(mk_row(11, "99723100000", 1'b1, 1'b0, '0));
    // 1800s code and month codes just off the valid bands
    dir_tab.push_back(mk_row(11, "99811200000", 1'b1, 1'b0, '0));
    dir_tab.push_back(mk_row(11, "50000100000", 1'b1, 1'b0, '0));
    dir_tab.push_back(mk_row(11, "50330100000", 1'b1, 1'b0, '0));
    // day past month end, day 99
    dir_tab.push_back(mk_row(11, "50043100000", 1'b1, 1'b0, '0));
    dir_tab.push_back(mk_row(11, "50019900000", 1'b1, 1'b0, '0));
    // characters just outside the digit range
    dir_tab.push_back(mk_row(11, "4405140145/", 1'b1, 1'b0, '0));
    dir_tab.push_back(mk_row(11, "44:51401458", 1'b1, 1'b0, '0));
    // lone byte extremes: short and non-digit, all fields zero
    dir_tab.push_back(mk_row(1, 8'h00, 1'b1, 1'b1, '0));
    dir_tab.push_back(mk_row(1, 8'hFF, 1'b1, 1'b1, '0));
    // short and overlong numbers
    dir_tab.push_back(mk_row(3, "123", 1'b1, 1'b0, '0));
    dir_tab.push_back(mk_row(16, "4405140145812345", 1'b1, 1'b0, '0));

    // bound settings: reset values first, then single years, a window,
    // crossed bounds, a random window and back to the full range
    lo_tab = '{MIN_YEAR_RST, 12'd2299, 12'd1900, 12'd2000, 12'd2200, 12'd1900, 12'd1900};
    hi_tab = '{MAX_YEAR_RST, 12'd2299, 12'd1900, 12'd2150, 12'd2000, 12'd2299, 12'd2299};
    lo_tab[5] = 12'($urandom_range(1900, 2299));
    hi_tab[5] = 12'($urandom_range(1900, 2299));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      r = dir_tab[i];
      if (r.pinned && r.close) begin
        pin_next = 1'b1;
        pinned_res = r.want;
      end
      for (int k = 0; k < r.len; k++)
        send_char(r.text[8 * (r.len - 1 - k) +: 8], r.close && (k == r.len - 1));
    end
    settle();

    quota = RANDOM_CHARS / NUM_PHASES;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph != 0) set_bounds(lo_tab[ph], hi_tab[ph]);
      quota = chars_sent + RANDOM_CHARS / NUM_PHASES;
      while (chars_sent < quota) begin
        // flip into and out of gap-free stretches now and then
        if ($urandom_range(0, 15) == 0) calm = !calm;
        make_number();
      end
      settle();
    end

    repeat (8) @(posedge clk);
    if (decoded_q.size() != 0) begin
      $error("%0d decodes never came out", decoded_q.size());
      err_cnt++;
    end
    $display("sent %0d characters over %0d year-bound settings, checked %0d decoded numbers",
             chars_sent, NUM_PHASES, results_seen);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
